>>> rtl/cmd5_pkg.sv
// Package: round constants, state codes and helper functions for the digest engine.
package cmd5_pkg;

  typedef enum logic [5:0] {
    S_IN     = 6'b000001,
    S_PAD    = 6'b000010,
    S_CSTART = 6'b000100,
    S_CMP    = 6'b001000,
    S_FIN    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    RET_IN,
    RET_PAD,
    RET_OUT
  } ret_e;

  typedef logic [31:0] ktab_t [64];

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic signed [63:0] QOne = 64'sh4000000000000000;
  localparam logic signed [63:0] T1  = QOne / 64'sd1;
  localparam logic signed [63:0] T2  = T1  / 64'sd2;
  localparam logic signed [63:0] T3  = T2  / 64'sd3;
  localparam logic signed [63:0] T4  = T3  / 64'sd4;
  localparam logic signed [63:0] T5  = T4  / 64'sd5;
  localparam logic signed [63:0] T6  = T5  / 64'sd6;
  localparam logic signed [63:0] T7  = T6  / 64'sd7;
  localparam logic signed [63:0] T8  = T7  / 64'sd8;
  localparam logic signed [63:0] T9  = T8  / 64'sd9;
  localparam logic signed [63:0] T10 = T9  / 64'sd10;
  localparam logic signed [63:0] T11 = T10 / 64'sd11;
  localparam logic signed [63:0] T12 = T11 / 64'sd12;
  localparam logic signed [63:0] T13 = T12 / 64'sd13;
  localparam logic signed [63:0] T14 = T13 / 64'sd14;
  localparam logic signed [63:0] T15 = T14 / 64'sd15;
  localparam logic signed [63:0] T16 = T15 / 64'sd16;
  localparam logic signed [63:0] T17 = T16 / 64'sd17;
  localparam logic signed [63:0] T18 = T17 / 64'sd18;
  localparam logic signed [63:0] T19 = T18 / 64'sd19;
  localparam logic signed [63:0] T20 = T19 / 64'sd20;
  localparam logic signed [63:0] T21 = T20 / 64'sd21;
  localparam logic signed [63:0] T22 = T21 / 64'sd22;
  localparam logic signed [63:0] T23 = T22 / 64'sd23;
  localparam logic signed [63:0] T24 = T23 / 64'sd24;
  localparam logic signed [63:0] T25 = T24 / 64'sd25;
  localparam logic signed [63:0] T26 = T25 / 64'sd26;
  localparam logic signed [63:0] T27 = T26 / 64'sd27;

  localparam logic signed [63:0] SinOne = T1 - T3 + T5 - T7 + T9 - T11 + T13 - T15
                                        + T17 - T19 + T21 - T23 + T25 - T27;
  localparam logic signed [63:0] CosOne = QOne - T2 + T4 - T6 + T8 - T10 + T12 - T14
                                        + T16 - T18 + T20 - T22 + T24 - T26;

  function automatic logic [63:0] fx_mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'b0, fx_mag(a)} * {64'b0, fx_mag(b)};
    r = p[125:62];
    return (a[63] != b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic ktab_t build_ktab();
    ktab_t k;
    logic signed [63:0] cn, sn, nc, ns;
    logic [63:0] v;
    cn = CosOne;
    sn = SinOne;
    for (int n = 0; n < 64; n++) begin
      v = fx_mag(cn) >> 30;
      k[n] = (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
      nc = fx_mul(cn, CosOne) - fx_mul(sn, SinOne);
      ns = fx_mul(sn, CosOne) + fx_mul(cn, SinOne);
      cn = nc;
      sn = ns;
    end
    return k;
  endfunction

  localparam ktab_t KTab = build_ktab();

  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    unique case (i[5:4])
      2'd0: return j;
      2'd1: return 4'(4'd5 * j + 4'd1);
      2'd2: return 4'(4'd3 * j + 4'd5);
      default: return 4'(4'd7 * j);
    endcase
  endfunction

  function automatic logic [4:0] shamt(input logic [5:0] i);
    unique case ({i[5:4], i[1:0]})
      4'h0: return 5'd7;
      4'h1: return 5'd12;
      4'h2: return 5'd17;
      4'h3: return 5'd22;
      4'h4: return 5'd5;
      4'h5: return 5'd9;
      4'h6: return 5'd14;
      4'h7: return 5'd20;
      4'h8: return 5'd4;
      4'h9: return 5'd11;
      4'hA: return 5'd16;
      4'hB: return 5'd23;
      4'hC: return 5'd6;
      4'hD: return 5'd10;
      4'hE: return 5'd15;
      default: return 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

>>> rtl/cosine_table_md5_digest.sv
// Top level: byte-serial MD5-style hash engine with cosine round constants.
//
//   channel | direction | fields
//   in      | sink      | msg_byte_i, byte_present_i, msg_last_i
//   out     | source    | digest_byte_o, digest_last_o
//
// Bytes are taken back to back while collecting; a full 64-byte block
// stalls input while compressed (a read setup, 64 rounds through the block
// RAM read port, a final add). A message end pads the block to word 15 and
// compresses it, again for an extra length block, then 16 output transfers.
// Reset clears control, the byte count and loads the initial chaining value.
// in_stall_o is high whenever the engine is not collecting bytes.
module cosine_table_md5_digest (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] msg_byte_i,
  input  logic       byte_present_i,
  input  logic       msg_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] digest_byte_o,
  output logic       digest_last_o
);
  import cmd5_pkg::*;

  state_e      state_q, state_d;
  ret_e        ret_q, ret_d;
  logic [60:0] cnt_q, cnt_d;
  logic [31:0] wbuf_q, wbuf_d;
  logic [3:0]  pw_q, pw_d;
  logic        pad2_q, pad2_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  oidx_q, oidx_d;
  logic [31:0] ch_q [4];
  logic [31:0] ch_d [4];
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [31:0] fval, sum, part;
  logic [63:0] bits;
  logic        in_xfer;

  cmd5_ram #(.Width(32), .Depth(16)) u_blk (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_stall_o    = (state_q != S_IN);
  assign in_xfer       = in_valid_i && (state_q == S_IN);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_last_o = out_valid_o && (oidx_q == 4'd15);
  assign digest_byte_o = ch_q[oidx_q[3:2]][oidx_q[1:0]*8 +: 8];
  assign bits          = {cnt_q, 3'b000};

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: part = {24'h0, PadByte};
      2'd1: part = {16'h0, PadByte, wbuf_q[7:0]};
      2'd2: part = {8'h0, PadByte, wbuf_q[15:0]};
      default: part = {PadByte, wbuf_q[23:0]};
    endcase
  end

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: fval = (b_q & c_q) | (~b_q & d_q);
      2'd1: fval = (b_q & d_q) | (c_q & ~d_q);
      2'd2: fval = b_q ^ c_q ^ d_q;
      default: fval = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + fval + KTab[rnd_q] + rdata;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    wbuf_d  = wbuf_q;
    pw_d    = pw_q;
    pad2_d  = pad2_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    ch_d    = ch_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    we      = 1'b0;
    waddr   = cnt_q[5:2];
    wdata   = {msg_byte_i, wbuf_q[23:0]};
    raddr   = msg_idx(6'd0);

    unique case (state_q)
      S_IN: begin
        if (in_xfer) begin
          if (byte_present_i) begin
            wbuf_d[cnt_q[1:0]*8 +: 8] = msg_byte_i;
            cnt_d = cnt_q + 61'd1;
            we    = (cnt_q[1:0] == 2'd3);
          end
          pw_d = cnt_d[5:2];
          if (byte_present_i && cnt_q[5:0] == 6'd63) begin
            ret_d   = msg_last_i ? RET_PAD : RET_IN;
            state_d = S_CSTART;
          end else if (msg_last_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        we    = 1'b1;
        waddr = pw_q;
        if (!pad2_q && pw_q == cnt_q[5:2]) begin
          wdata = part;
        end else if ((pad2_q || cnt_q[5:3] != 3'b111) && pw_q == 4'd14) begin
          wdata = bits[31:0];
        end else if ((pad2_q || cnt_q[5:3] != 3'b111) && pw_q == 4'd15) begin
          wdata = bits[63:32];
        end else begin
          wdata = '0;
        end
        pw_d = pw_q + 4'd1;
        if (pw_q == 4'd15) begin
          state_d = S_CSTART;
          if (!pad2_q && cnt_q[5:3] == 3'b111) begin
            pad2_d = 1'b1;
            ret_d  = RET_PAD;
          end else begin
            ret_d  = RET_OUT;
          end
        end
      end
      S_CSTART: begin
        raddr   = msg_idx(6'd0);
        rnd_d   = '0;
        a_d     = ch_q[0];
        b_d     = ch_q[1];
        c_d     = ch_q[2];
        d_d     = ch_q[3];
        state_d = S_CMP;
      end
      S_CMP: begin
        raddr = msg_idx(rnd_q + 6'd1);
        a_d   = d_q;
        d_d   = c_q;
        c_d   = b_q;
        b_d   = b_q + rotl(sum, shamt(rnd_q));
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ch_d[0] = ch_q[0] + a_q;
        ch_d[1] = ch_q[1] + b_q;
        ch_d[2] = ch_q[2] + c_q;
        ch_d[3] = ch_q[3] + d_q;
        pw_d    = pad2_q ? 4'd0 : cnt_q[5:2];
        oidx_d  = '0;
        unique case (ret_q)
          RET_IN:  state_d = S_IN;
          RET_PAD: state_d = S_PAD;
          default: state_d = S_OUT;
        endcase
      end
      default: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 4'd1;
          if (oidx_q == 4'd15) begin
            ch_d[0] = KTab[8];
            ch_d[1] = KTab[5];
            ch_d[2] = KTab[2];
            ch_d[3] = KTab[0];
            cnt_d   = '0;
            pad2_d  = 1'b0;
            state_d = S_IN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      ret_q   <= RET_IN;
      cnt_q   <= '0;
      pw_q    <= '0;
      pad2_q  <= 1'b0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      ch_q[0] <= KTab[8];
      ch_q[1] <= KTab[5];
      ch_q[2] <= KTab[2];
      ch_q[3] <= KTab[0];
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      pw_q    <= pw_d;
      pad2_q  <= pad2_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
  end

endmodule

>>> rtl/cmd5_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cmd5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/cmd5_chk.sv
// Checker: port-level properties of the digest engine, bound to the top level.
module cmd5_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       msg_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] digest_byte_o,
  input logic       digest_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_byte_o)
      && $stable(digest_last_o))
    else $error("stalled digest transfer changed");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while digest is emitted");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && digest_last_o |=> !out_valid_o && !in_stall_o)
    else $error("engine did not return to input after last digest byte");

  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && msg_last_i |=> in_stall_o)
    else $error("input not stalled after message end");

endmodule

bind cosine_table_md5_digest cmd5_chk u_cmd5_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .msg_last_i   (msg_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .digest_byte_o(digest_byte_o),
  .digest_last_o(digest_last_o)
);
